// ===== sv/ilid_pkg.sv =====
`default_nettype none

package ilid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 11;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 7;
    localparam int FAN_LOG      = 3;
    localparam int WAIT_W       = 3;

    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_INS_HEAD = 3'd1,
        KIND_INS_TAIL = 3'd2,
        KIND_INS_POS  = 3'd3,
        KIND_DELETE   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic                   rd_en;
        logic [POS_W-1:0]       pos;
        logic [VAL_W-1:0]       val;
    } cell_ctl_t;

    // number of registered levels above the leaves, eight inputs per node
    function automatic int tree_levels(input int n);
        int lv;
        lv = 0;
        for (int k = 1; k < 8; k++)
        begin
            if (lv == 0 && (1 << (FAN_LOG * k)) >= n)
            begin
                lv = k;
            end
        end
        return lv;
    endfunction

    // first node of a level in the flat node array
    function automatic int tree_off(input int l, input int levels);
        int off;
        off = 0;
        for (int m = 0; m < 8; m++)
        begin
            if (m < l)
            begin
                off = off + (1 << (FAN_LOG * (levels - m)));
            end
        end
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ilid_cell.sv =====
`default_nettype none

module ilid_cell
    import ilid_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire                    clk,
    input  cell_ctl_t              ctl,
    input  wire  [VAL_W-1:0]       left,
    input  wire  [VAL_W-1:0]       right,
    output logic [VAL_W-1:0]       data,
    output logic [VAL_W-1:0]       rd_data
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [VAL_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            CELL_INS:
            begin
                if (MY_IDX > ctl.pos)
                begin
                    data_reg <= left;
                end
                else if (MY_IDX == ctl.pos)
                begin
                    data_reg <= ctl.val;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= ctl.pos)
                begin
                    data_reg <= right;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign data    = data_reg;
    assign rd_data = (ctl.rd_en && MY_IDX == ctl.pos) ? data_reg : '0;

endmodule

`default_nettype wire

// ===== sv/ilid_or_tree.sv =====
`default_nettype none

module ilid_or_tree
    import ilid_pkg::*;
#(
    parameter int N = CAPACITY_DEF
)
(
    input  wire                    clk,
    input  wire  [N*VAL_W-1:0]     leaf,
    output logic [VAL_W-1:0]       root
);

    localparam int LV  = tree_levels(N);
    localparam int PL  = 1 << (FAN_LOG * LV);
    localparam int TOT = tree_off(LV + 1, LV);

    logic [VAL_W-1:0] node_reg [TOT];

    for (genvar j = 0; j < PL; j++)
    begin : g_leaf
        if (j < N)
        begin : g_used
            always_ff @(posedge clk)
            begin
                node_reg[j] <= leaf[j*VAL_W +: VAL_W];
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                node_reg[j] <= '0;
            end
        end
    end

    for (genvar l = 1; l <= LV; l++)
    begin : g_lvl
        for (genvar j = 0; j < (PL >> (FAN_LOG * l)); j++)
        begin : g_node
            logic [VAL_W-1:0] or_next;

            always_comb
            begin
                or_next = '0;
                for (int k = 0; k < (1 << FAN_LOG); k++)
                begin
                    or_next = or_next
                        | node_reg[tree_off(l - 1, LV) + (j << FAN_LOG) + k];
                end
            end

            always_ff @(posedge clk)
            begin
                node_reg[tree_off(l, LV) + j] <= or_next;
            end
        end
    end

    assign root = node_reg[TOT-1];

endmodule

`default_nettype wire

// ===== sv/indexed_list_insert_delete.sv =====
// operation: requests are handled strictly in turn; the read value is gathered
// from the cell row by the registered or-tree, which has levels =
// ceil(log8(CAPACITY)) registered levels above its leaf registers, and no
// new request is accepted until the result transfer has been taken
// reset: element count cleared to zero, no transfer pending; cell contents
// are undefined until written
`default_nettype none

module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // position[15:0], value[47:16]
    input  wire  [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // read_value[31:0], status[33:32],
                                        // count[40:34], zero[47:41]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LV = tree_levels(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [WAIT_W-1:0]      wait_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   rd_sel_reg;
    logic [VAL_W-1:0]       rv_const_reg;
    status_t                st_reg;
    logic [VAL_W-1:0]       read_value_reg;

    logic                   s_fire;
    logic [15:0]            position;
    logic [VAL_W-1:0]       value;
    logic [15:0]            cnt16;
    logic                   in_range;
    logic [15:0]            ins_p;
    logic                   full;
    cell_ctl_t              ctl;
    cell_ctl_t              cell_ctl;
    status_t                st_next;
    logic                   rd_sel_next;
    logic [VAL_W-1:0]       rv_const_next;

    logic [VAL_W-1:0]           cell_data [CAPACITY];
    logic [CAPACITY*VAL_W-1:0]  leaf;
    logic [VAL_W-1:0]           root;

    assign position = s_axis_tdata[15:0];
    assign value    = s_axis_tdata[47:16];
    assign cnt16    = 16'(count_reg);
    assign in_range = !position[15] && (position < cnt16);
    assign full     = (count_reg == CW'(CAPACITY));
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        unique case (kind_t'(s_axis_tuser))
            KIND_INS_TAIL: ins_p = cnt16;
            KIND_INS_POS:  ins_p = position[15] ? 16'd0 : position;
            default:       ins_p = 16'd0;
        endcase
    end

    always_comb
    begin
        ctl.op        = CELL_HOLD;
        ctl.rd_en     = 1'b0;
        ctl.pos       = position[POS_W-1:0];
        ctl.val       = value;
        st_next       = ST_DONE;
        rd_sel_next   = 1'b0;
        rv_const_next = '0;
        count_next    = count_reg;
        unique case (kind_t'(s_axis_tuser))
            KIND_READ:
            begin
                if (in_range)
                begin
                    ctl.rd_en   = 1'b1;
                    rd_sel_next = 1'b1;
                end
                else
                begin
                    st_next       = ST_RANGE;
                    rv_const_next = '1;
                end
            end
            KIND_DELETE:
            begin
                if (in_range)
                begin
                    ctl.op     = CELL_DEL;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    st_next = ST_RANGE;
                end
            end
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_POS:
            begin
                ctl.pos = ins_p[POS_W-1:0];
                if (ins_p > cnt16)
                begin
                    st_next = ST_RANGE;
                end
                else if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    ctl.op     = CELL_INS;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                st_next = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctl = ctl;
        if (!s_fire)
        begin
            cell_ctl.op = CELL_HOLD;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid_r
            assign right = cell_data[i+1];
        end

        ilid_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .left    (left),
            .right   (right),
            .data    (cell_data[i]),
            .rd_data (leaf[i*VAL_W +: VAL_W])
        );
    end

    ilid_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wait_reg       <= '0;
            count_reg      <= '0;
            rd_sel_reg     <= 1'b0;
            rv_const_reg   <= '0;
            st_reg         <= ST_DONE;
            read_value_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg    <= S_BUSY;
                        wait_reg     <= WAIT_W'(LV);
                        count_reg    <= count_next;
                        rd_sel_reg   <= rd_sel_next;
                        rv_const_reg <= rv_const_next;
                        st_reg       <= st_next;
                    end
                end
                S_BUSY:
                begin
                    if (wait_reg == '0)
                    begin
                        read_value_reg <= rd_sel_reg ? root : rv_const_reg;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - WAIT_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_DONE);
    assign m_axis_tdata  = {7'd0, CNT_OUT_W'(count_reg), st_reg, read_value_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("new request taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && cell_ctl.op == CELL_INS |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st_reg == ST_FULL |-> count_reg == CW'(CAPACITY))
        else $error("full status without a full store");

endmodule

`default_nettype wire

// ===== tb/sv/tb_indexed_list_insert_delete.sv =====
`default_nettype none

module tb_indexed_list_insert_delete;
    import ilid_pkg::*;

    localparam logic [2:0] KIND_UNKNOWN_LO = 3'd5;

    typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} mix_t;

    typedef struct {
        logic [31:0] read_value;
        status_t     status;
        logic [6:0]  count;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  cells [CAPACITY_DEF];
        int           n_elems;
        list_result_t result_q [$];
        int unsigned  mismatches;
        int unsigned  kind_seen [8];
        int unsigned  status_seen [4];

        function new();
            n_elems = 0;
            mismatches = 0;
            foreach (kind_seen[i])
            begin
                kind_seen[i] = 0;
            end
            foreach (status_seen[i])
            begin
                status_seen[i] = 0;
            end
        endfunction

        function void note_request(input logic [2:0] kind, input logic [15:0] pos,
                                   input logic [31:0] val);
            list_result_t r;
            int p;
            int ip;
            p = int'($signed(pos));
            r.read_value = '0;
            r.status = ST_DONE;
            if (kind == KIND_READ || kind == KIND_DELETE)
            begin
                if (p < 0 || p >= n_elems)
                begin
                    r.status = ST_RANGE;
                    if (kind == KIND_READ)
                    begin
                        r.read_value = '1;
                    end
                end
                else if (kind == KIND_READ)
                begin
                    r.read_value = cells[p];
                end
                else
                begin
                    for (int i = p; i + 1 < n_elems; i++)
                    begin
                        cells[i] = cells[i + 1];
                    end
                    n_elems--;
                end
            end
            else if (kind == KIND_INS_HEAD || kind == KIND_INS_TAIL || kind == KIND_INS_POS)
            begin
                if (kind == KIND_INS_HEAD)
                begin
                    ip = 0;
                end
                else if (kind == KIND_INS_TAIL)
                begin
                    ip = n_elems;
                end
                else
                begin
                    ip = (p < 0) ? 0 : p;
                end
                if (ip > n_elems)
                begin
                    r.status = ST_RANGE;
                end
                else if (n_elems >= CAPACITY_DEF)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = n_elems; i > ip; i--)
                    begin
                        cells[i] = cells[i - 1];
                    end
                    cells[ip] = val;
                    n_elems++;
                end
            end
            else
            begin
                r.status = ST_RANGE;
            end
            r.count = 7'(n_elems);
            result_q.push_back(r);
            kind_seen[kind]++;
            status_seen[r.status]++;
        endfunction

        function void check_result(input logic [47:0] d);
            list_result_t r;
            if (result_q.size() == 0)
            begin
                $error("result transfer with no request pending: %h", d);
                mismatches++;
                return;
            end
            r = result_q.pop_front();
            if (d[31:0] !== r.read_value)
            begin
                $error("read_value: expected %0d, actual %0d",
                       $signed(r.read_value), $signed(d[31:0]));
                mismatches++;
            end
            if (d[33:32] !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, d[33:32]);
                mismatches++;
            end
            if (d[40:34] !== r.count)
            begin
                $error("count: expected %0d, actual %0d", r.count, d[40:34]);
                mismatches++;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // position[15:0], value[47:16]
    logic [2:0]  s_axis_tuser;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_value[31:0], status[33:32], count[40:34]

    list_scoreboard sb;
    bit hold_req;
    bit calm;

    indexed_list_insert_delete dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // result side ready pattern
    initial
    begin
        int n;
        int r;
        m_axis_tready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 15);
                end
                else if (r < 8)
                begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 15);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(40, 100);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin
        #3200000;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    task automatic send_request(input logic [2:0] kind, input logic [15:0] pos,
                                input logic [31:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, pos};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_request(kind, pos, val);
    endtask

    task automatic idle_sender(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic pick_request(input mix_t mode, output logic [2:0] kind,
                                output logic [15:0] pos, output logic [31:0] val);
        int n;
        int w;
        int r;
        int ins_w;
        int rd_w;
        n = sb.n_elems;
        case (mode)
            MODE_FILL:  begin ins_w = 70; rd_w = 18; end
            MODE_DRAIN: begin ins_w = 15; rd_w = 25; end
            default:    begin ins_w = 35; rd_w = 33; end
        endcase
        w = $urandom_range(0, 99);
        if (w < 2)
        begin
            kind = KIND_UNKNOWN_LO + 3'($urandom_range(0, 2));
        end
        else if (w < 2 + ins_w)
        begin
            r = $urandom_range(0, 3);
            kind = (r == 0) ? KIND_INS_HEAD : (r == 1) ? KIND_INS_TAIL : KIND_INS_POS;
        end
        else if (w < 2 + ins_w + rd_w)
        begin
            kind = KIND_READ;
        end
        else
        begin
            kind = KIND_DELETE;
        end
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            if (kind == KIND_INS_POS)
            begin
                pos = 16'($urandom_range(0, n));
            end
            else
            begin
                pos = 16'($urandom_range(0, (n > 0) ? n - 1 : 0));
            end
        end
        else if (r < 92)
        begin
            pos = 16'(n + $urandom_range(0, 3));
        end
        else if (r < 96)
        begin
            pos = -16'($urandom_range(1, 8));
        end
        else
        begin
            pos = 16'($urandom());
        end
        val = $urandom();
    endtask

    initial
    begin
        logic [2:0]  k;
        logic [15:0] p;
        logic [31:0] v;
        mix_t        mode;
        int          sent;
        int          phase_len;
        bit          gappy;
        sb = new();
        hold_req = 1'b0;
        calm = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, clamping, past-the-end inserts
        send_request(KIND_READ, 16'h0000, 32'h0);
        send_request(KIND_DELETE, 16'h0000, 32'h0);
        send_request(KIND_INS_POS, 16'h0001, 32'h0000_1234);
        send_request(KIND_INS_POS, 16'h8000, 32'h8000_0000);
        send_request(KIND_INS_TAIL, 16'h0000, 32'h7FFF_FFFF);
        send_request(KIND_INS_HEAD, 16'hFFFF, 32'h0000_0000);
        send_request(KIND_INS_POS, 16'h7FFF, 32'h0000_0005);
        send_request(KIND_INS_POS, 16'h0001, 32'hFFFF_FFFF);
        send_request(KIND_INS_POS, 16'h0004, 32'h5555_AAAA);
        for (int i = 0; i < 6; i++)
        begin
            send_request(KIND_READ, 16'(i), 32'h0);
        end
        send_request(KIND_READ, 16'hFFFF, 32'h0);
        send_request(KIND_READ, 16'h8000, 32'h0);
        send_request(KIND_DELETE, 16'hFFFF, 32'h0);
        send_request(KIND_DELETE, 16'h7FFF, 32'h0);
        send_request(KIND_DELETE, 16'h0004, 32'h0);
        send_request(KIND_DELETE, 16'h0000, 32'h0);
        for (int i = 0; i < 3; i++)
        begin
            send_request(KIND_UNKNOWN_LO + 3'(i), 16'($urandom()), $urandom());
        end
        wait_drained();

        sent = 0;
        mode = MODE_FILL;
        while (sent < 1250)
        begin
            phase_len = $urandom_range(40, 120);
            gappy = ($urandom_range(0, 3) != 0);
            if (sent >= 1100)
            begin
                calm = 1'b1;
            end
            repeat (phase_len)
            begin
                if (sent == 400)
                begin
                    // long result stall while requests keep coming
                    hold_req = 1'b1;
                    repeat (40)
                    begin
                        pick_request(mode, k, p, v);
                        send_request(k, p, v);
                        sent++;
                    end
                    wait_drained();
                end
                pick_request(mode, k, p, v);
                send_request(k, p, v);
                sent++;
                if (gappy && !calm && $urandom_range(0, 3) == 0)
                begin
                    idle_sender($urandom_range(1, 15));
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drained();
            end
            mode = mix_t'($urandom_range(0, 2));
        end
        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d requests: %0d reads, %0d inserts, %0d deletes, %0d unknown kinds",
                 sb.kind_seen.sum(), sb.kind_seen[KIND_READ],
                 sb.kind_seen[KIND_INS_HEAD] + sb.kind_seen[KIND_INS_TAIL]
                 + sb.kind_seen[KIND_INS_POS], sb.kind_seen[KIND_DELETE],
                 sb.kind_seen[5] + sb.kind_seen[6] + sb.kind_seen[7]);
        $display("outcomes: %0d done, %0d out of range, %0d rejected on a full store",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_RANGE], sb.status_seen[ST_FULL]);
        if (sb.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== indexed_list_insert_delete.f =====
sv/ilid_pkg.sv
sv/ilid_cell.sv
sv/ilid_or_tree.sv
sv/indexed_list_insert_delete.sv
tb/sv/tb_indexed_list_insert_delete.sv
